// ----- rtl/sha256_pkg.sv -----
package sha256_pkg;

    typedef logic [31:0] word_t;

    localparam int unsigned NumRounds = 64;
    localparam int unsigned BlockWords = 16;
    localparam int unsigned HashWords = 8;

    localparam logic [7:0] PadMarker = 8'h80;
    localparam logic [5:0] LenOffset = 6'd56;

    function automatic word_t round_const(input logic [5:0] idx);
        word_t k;
        case (idx)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic word_t init_hash(input logic [2:0] idx);
        word_t h;
        case (idx)
            3'd0: h = 32'h6a09e667;
            3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372;
            3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f;
            3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;
            3'd7: h = 32'h5be0cd19;
            default: h = 32'h0;
        endcase
        return h;
    endfunction

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ----- rtl/sha256_stream_hasher_unit.sv -----
// A request with a byte is taken only while idle; every 64th byte then starts a
// compression: the block memory is loaded into the schedule, 64 rounds run at one
// per cycle and the result is added into the hash memory. A message end adds the
// padding bytes at one per cycle, one or two compressions, and then reads, captures
// and offers each digest word in turn. Reset clears all control state and marks the
// hash memory as holding the initial hash values; the block memory is not cleared.
module sha256_stream_hasher_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        message_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_number,
    output logic        last_word
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_ROUND = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_ORD   = 3'd5;
    localparam logic [2:0] S_OCAP  = 3'd6;
    localparam logic [2:0] S_OWAIT = 3'd7;

    logic [2:0]  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] len_reg, len_next;
    logic [23:0] word_reg, word_next;
    logic        pad_active_reg, pad_active_next;
    logic        pad_first_reg, pad_first_next;
    logic        len_ok_reg, len_ok_next;
    logic        final_reg, final_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [2:0]  oj_reg, oj_next;
    logic [7:0]  hvalid_reg, hvalid_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_word_reg, out_word_next;

    sha256_pkg::word_t v_reg [8];
    sha256_pkg::word_t v_next [8];
    sha256_pkg::word_t w_reg [16];
    sha256_pkg::word_t w_next [16];

    // Block memory, one 32-bit big-endian word per entry.
    sha256_pkg::word_t w_mem [16];
    logic        wm_we;
    logic [3:0]  wm_waddr, wm_raddr;
    sha256_pkg::word_t wm_wdata, wm_rdata;

    // Chaining value memory.
    sha256_pkg::word_t h_mem [8];
    logic        hm_we;
    logic [2:0]  hm_waddr, hm_raddr;
    sha256_pkg::word_t hm_wdata, hm_rdata;
    logic [2:0]  h_addr_reg;
    logic        h_ok_reg;
    sha256_pkg::word_t h_val;

    logic        accept;
    logic        byte_go;
    logic [7:0]  byte_val;
    logic        wrap;
    logic [63:0] len_shift;
    sha256_pkg::word_t t1, t2, w_new;

    always_ff @(posedge clk)
    begin
        if (wm_we)
        begin
            w_mem[wm_waddr] <= wm_wdata;
        end
        wm_rdata <= w_mem[wm_raddr];
        if (hm_we)
        begin
            h_mem[hm_waddr] <= hm_wdata;
        end
        hm_rdata <= h_mem[hm_raddr];
    end

    // Entries of the hash memory never written since the last digest read as the IV.
    assign h_val = h_ok_reg ? hm_rdata : sha256_pkg::init_hash(h_addr_reg);

    assign in_stall = (state_reg != S_IDLE);
    assign accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign digest_word = out_word_reg;
    assign word_number = oj_reg;
    assign last_word = (oj_reg == 3'd7);

    assign len_shift = len_reg >> {(3'd7 - fill_reg[2:0]), 3'b000};

    always_comb
    begin
        t1 = v_reg[7] + sha256_pkg::big_sigma1(v_reg[4])
             + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
             + sha256_pkg::round_const(cnt_reg) + w_reg[0];
        t2 = sha256_pkg::big_sigma0(v_reg[0])
             + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        w_new = w_reg[0] + sha256_pkg::small_sigma0(w_reg[1]) + w_reg[9]
                + sha256_pkg::small_sigma1(w_reg[14]);
    end

    always_comb
    begin
        state_next = state_reg;
        fill_next = fill_reg;
        len_next = len_reg;
        word_next = word_reg;
        pad_active_next = pad_active_reg;
        pad_first_next = pad_first_reg;
        len_ok_next = len_ok_reg;
        final_next = final_reg;
        cnt_next = cnt_reg;
        oj_next = oj_reg;
        hvalid_next = hvalid_reg;
        out_valid_next = out_valid_reg;
        out_word_next = out_word_reg;
        v_next = v_reg;
        w_next = w_reg;
        wm_we = 1'b0;
        wm_waddr = fill_reg[5:2];
        wm_raddr = cnt_reg[3:0];
        hm_we = 1'b0;
        hm_waddr = cnt_reg[2:0] - 3'd1;
        hm_raddr = cnt_reg[2:0];
        hm_wdata = h_val + v_reg[0];
        byte_go = 1'b0;
        byte_val = data_byte;
        wrap = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                byte_go = accept && byte_present;
            end
            S_PAD:
            begin
                byte_go = 1'b1;
                if (pad_first_reg)
                begin
                    byte_val = sha256_pkg::PadMarker;
                end
                else if (len_ok_reg && (fill_reg >= sha256_pkg::LenOffset))
                begin
                    byte_val = len_shift[7:0];
                end
                else
                begin
                    byte_val = 8'h00;
                end
            end
            default:
            begin
                byte_go = 1'b0;
            end
        endcase

        wm_wdata = {word_reg, byte_val};
        if (byte_go)
        begin
            word_next = {word_reg[15:0], byte_val};
            wm_we = (fill_reg[1:0] == 2'd3);
            fill_next = fill_reg + 6'd1;
            wrap = (fill_reg == 6'd63);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (byte_go)
                begin
                    len_next = len_reg + 64'd8;
                end
                if (accept && message_end)
                begin
                    pad_active_next = 1'b1;
                    pad_first_next = 1'b1;
                    len_ok_next = 1'b0;
                    final_next = 1'b0;
                    state_next = S_PAD;
                end
                if (wrap)
                begin
                    cnt_next = 6'd0;
                    state_next = S_LOAD;
                end
            end
            S_PAD:
            begin
                pad_first_next = 1'b0;
                if (pad_first_reg && (fill_reg < sha256_pkg::LenOffset))
                begin
                    len_ok_next = 1'b1;
                end
                if (wrap)
                begin
                    if (len_ok_reg)
                    begin
                        final_next = 1'b1;
                    end
                    else
                    begin
                        len_ok_next = 1'b1;
                    end
                    cnt_next = 6'd0;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                // Read data of the previous cycle is captured in every load step but the first.
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg != 6'd0)
                begin
                    for (int i = 0; i < 15; i++)
                    begin
                        w_next[i] = w_reg[i + 1];
                    end
                    w_next[15] = wm_rdata;
                    if (cnt_reg <= 6'd8)
                    begin
                        for (int i = 0; i < 7; i++)
                        begin
                            v_next[i] = v_reg[i + 1];
                        end
                        v_next[7] = h_val;
                    end
                end
                if (cnt_reg == 6'd16)
                begin
                    cnt_next = 6'd0;
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_next[i] = w_reg[i + 1];
                end
                w_next[15] = w_new;
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    cnt_next = 6'd0;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg != 6'd0)
                begin
                    hm_we = 1'b1;
                    hvalid_next[hm_waddr] = 1'b1;
                    for (int i = 0; i < 7; i++)
                    begin
                        v_next[i] = v_reg[i + 1];
                    end
                end
                if (cnt_reg == 6'd8)
                begin
                    cnt_next = 6'd0;
                    if (final_reg)
                    begin
                        oj_next = 3'd0;
                        state_next = S_ORD;
                    end
                    else if (pad_active_reg)
                    begin
                        state_next = S_PAD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ORD:
            begin
                hm_raddr = oj_reg;
                state_next = S_OCAP;
            end
            S_OCAP:
            begin
                out_word_next = h_val;
                out_valid_next = 1'b1;
                state_next = S_OWAIT;
            end
            S_OWAIT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    if (oj_reg == 3'd7)
                    begin
                        hvalid_next = 8'h00;
                        fill_next = 6'd0;
                        len_next = 64'd0;
                        pad_active_next = 1'b0;
                        pad_first_next = 1'b0;
                        len_ok_next = 1'b0;
                        final_next = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        oj_next = oj_reg + 3'd1;
                        state_next = S_ORD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg <= 6'd0;
            len_reg <= 64'd0;
            pad_active_reg <= 1'b0;
            pad_first_reg <= 1'b0;
            len_ok_reg <= 1'b0;
            final_reg <= 1'b0;
            cnt_reg <= 6'd0;
            oj_reg <= 3'd0;
            hvalid_reg <= 8'h00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            len_reg <= len_next;
            pad_active_reg <= pad_active_next;
            pad_first_reg <= pad_first_next;
            len_ok_reg <= len_ok_next;
            final_reg <= final_next;
            cnt_reg <= cnt_next;
            oj_reg <= oj_next;
            hvalid_reg <= hvalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        out_word_reg <= out_word_next;
        v_reg <= v_next;
        w_reg <= w_next;
        h_addr_reg <= hm_raddr;
        h_ok_reg <= hvalid_reg[hm_raddr];
    end

`ifndef SYNTHESIS
    a_out_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (state_reg == S_OWAIT))
        else $error("result shown outside the output wait state");

    a_load_on_full_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_LOAD) && (state_next == S_LOAD) |-> (fill_next == 6'd0))
        else $error("compression started on a partial block");

    a_clear_after_digest: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last_word |=> (fill_reg == 6'd0) && (len_reg == 64'd0)
            && (hvalid_reg == 8'h00))
        else $error("message state not cleared after the last digest word");

    a_no_request_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) |=> in_stall)
        else $error("request taken during compression");
`endif

endmodule
